// ----- hw/rtl/rwcl_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rwcl_pkg
// Shared types and constants for the RIFF/WAVE chunk locator.
// ============================================================================
package rwcl_pkg;

    // Byte-stream word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } byte_word_t;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [32:0] fmt_offset;
        logic [32:0] data_offset;
        logic [31:0] data_size;
    } result_word_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_CHDR,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // FOURCC tags, little endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN = 32'd14;

    // Fixed header offsets
    localparam logic [32:0] POS_RIFF_TAG  = 33'd3;
    localparam logic [32:0] POS_RIFF_LEN  = 33'd7;
    localparam logic [32:0] POS_WAVE_TAG  = 33'd11;
    localparam logic [32:0] POS_FIRST_CHK = 33'd12;

    // Chunk header byte indexes
    localparam logic [2:0] HK_BODY = 3'd0;
    localparam logic [2:0] HK_REM  = 3'd1;
    localparam logic [2:0] HK_TAG  = 3'd3;
    localparam logic [2:0] HK_LEN  = 3'd7;

    // Configuration map
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_NEED_FORMAT = 3'd0;

endpackage

// ----- hw/rtl/rwcl_regs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rwcl_regs
// APB-style configuration register file (need_format).
// ============================================================================
module rwcl_regs
    import rwcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic               need_format
);

    logic need_format_reg;
    logic need_format_next;
    logic hit;

    assign hit    = (paddr[PADDR_W-1:2] == ADDR_NEED_FORMAT[PADDR_W-1:2]);
    assign pready = 1'b1;

    always_comb
    begin
        need_format_next = need_format_reg;
        if (psel && penable && pwrite && hit)
        begin
            need_format_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_format_reg <= 1'b1;
        end
        else
        begin
            need_format_reg <= need_format_next;
        end
    end

    assign prdata      = hit ? {31'd0, need_format_reg} : 32'd0;
    assign need_format = need_format_reg;

endmodule

// ----- hw/rtl/rwcl_parse.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rwcl_parse
// Per-byte parse state and next-state logic; one byte per step.
// ============================================================================
module rwcl_parse
    import rwcl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  byte_word_t   item,
    input  logic         need_format,
    output logic         res_valid,
    output result_word_t res
);

    phase_t             phase_reg, phase_next;
    logic        [32:0] pos_reg, pos_next;
    logic        [31:0] ws_reg, ws_next;
    logic        [32:0] end_reg, end_next;
    logic        [31:0] tag_reg, tag_next;
    logic        [32:0] ncp_reg, ncp_next;
    logic        [32:0] body_reg, body_next;
    logic signed [33:0] rem_reg, rem_next;
    logic        [2:0]  hcnt_reg, hcnt_next;
    logic               fmt_found_reg, fmt_found_next;
    logic        [32:0] fmt_off_reg, fmt_off_next;
    logic               data_seen_reg, data_seen_next;
    logic        [32:0] data_off_reg, data_off_next;
    logic        [31:0] data_len_reg, data_len_next;

    phase_t             c_phase;
    logic        [2:0]  hk;
    logic        [31:0] len;
    logic        [31:0] rounded;
    logic        [33:0] nxt;
    logic               past_end;
    logic               fin;
    logic        [2:0]  fin_status;

    always_comb
    begin
        // start_req clears parse state before the byte is taken
        c_phase        = item.start_req ? PH_HEAD : phase_reg;
        pos_next       = item.start_req ? 33'd0 : pos_reg;
        ws_next        = item.start_req ? 32'd0 : ws_reg;
        end_next       = item.start_req ? 33'd0 : end_reg;
        tag_next       = item.start_req ? 32'd0 : tag_reg;
        ncp_next       = item.start_req ? 33'd0 : ncp_reg;
        body_next      = body_reg;
        rem_next       = rem_reg;
        hcnt_next      = hcnt_reg;
        fmt_found_next = item.start_req ? 1'b0 : fmt_found_reg;
        fmt_off_next   = item.start_req ? 33'd0 : fmt_off_reg;
        data_seen_next = item.start_req ? 1'b0 : data_seen_reg;
        data_off_next  = item.start_req ? 33'd0 : data_off_reg;
        data_len_next  = item.start_req ? 32'd0 : data_len_reg;
        phase_next     = c_phase;
        fin            = 1'b0;
        fin_status     = ST_OK;
        hk             = hcnt_reg;
        len            = 32'd0;
        rounded        = 32'd0;
        nxt            = 34'd0;
        past_end       = 1'b0;

        if (c_phase != PH_DONE)
        begin
            ws_next = {item.data_byte, ws_next[31:8]};

            if (c_phase == PH_SKIP)
            begin
                hk = HK_BODY;
                if (pos_next == ncp_next)
                begin
                    phase_next = PH_CHDR;
                end
            end

            unique case (phase_next)
                PH_HEAD:
                begin
                    if (pos_next == POS_RIFF_TAG)
                    begin
                        if (ws_next != TAG_RIFF)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_NOT_RIFF;
                        end
                    end
                    else if (pos_next == POS_RIFF_LEN)
                    begin
                        end_next = 33'd8 + {1'b0, ws_next};
                    end
                    else if (pos_next == POS_WAVE_TAG)
                    begin
                        if (ws_next != TAG_WAVE)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_NOT_WAVE;
                        end
                        else
                        begin
                            ncp_next = POS_FIRST_CHK;
                            if (POS_FIRST_CHK >= end_next)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                phase_next = PH_CHDR;
                                hcnt_next  = HK_BODY;
                            end
                        end
                    end
                end
                PH_CHDR:
                begin
                    hcnt_next = hk + 3'd1;
                    if (hk == HK_BODY)
                    begin
                        body_next = ncp_next + 33'd8;
                    end
                    else if (hk == HK_REM)
                    begin
                        // room left from body start to end of RIFF
                        rem_next = $signed({1'b0, end_next}) - $signed({1'b0, body_reg});
                    end
                    else if (hk == HK_TAG)
                    begin
                        tag_next = ws_next;
                    end
                    else if (hk == HK_LEN)
                    begin
                        len      = ws_next;
                        rounded  = {len[31:1] + {30'd0, len[0]}, 1'b0};
                        nxt      = {1'b0, body_reg} + {2'd0, rounded};
                        past_end = ($signed({2'b00, rounded}) >= rem_reg);

                        if (tag_next == TAG_FMT)
                        begin
                            if (need_format && !fmt_found_next)
                            begin
                                if (len < FMT_MIN_LEN)
                                begin
                                    fin        = 1'b1;
                                    fin_status = ST_FMT_SHORT;
                                end
                                else
                                begin
                                    fmt_found_next = 1'b1;
                                    fmt_off_next   = body_reg;
                                    if (data_seen_next && (data_len_next != 32'd0))
                                    begin
                                        fin        = 1'b1;
                                        fin_status = ST_OK;
                                    end
                                end
                            end
                        end
                        else if (tag_next == TAG_DATA)
                        begin
                            if (!data_seen_next || (data_len_next == 32'd0))
                            begin
                                data_seen_next = 1'b1;
                                data_off_next  = body_reg;
                                data_len_next  = len;
                                if (!need_format || fmt_found_next)
                                begin
                                    fin        = 1'b1;
                                    fin_status = ST_OK;
                                end
                            end
                        end

                        if (!fin)
                        begin
                            if (past_end)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ncp_next   = nxt[32:0];
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            if (fin)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                pos_next = pos_next + 33'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            pos_reg       <= 33'd0;
            ws_reg        <= 32'd0;
            end_reg       <= 33'd0;
            tag_reg       <= 32'd0;
            ncp_reg       <= 33'd0;
            body_reg      <= 33'd0;
            rem_reg       <= 34'sd0;
            hcnt_reg      <= 3'd0;
            fmt_found_reg <= 1'b0;
            fmt_off_reg   <= 33'd0;
            data_seen_reg <= 1'b0;
            data_off_reg  <= 33'd0;
            data_len_reg  <= 32'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            ws_reg        <= ws_next;
            end_reg       <= end_next;
            tag_reg       <= tag_next;
            ncp_reg       <= ncp_next;
            body_reg      <= body_next;
            rem_reg       <= rem_next;
            hcnt_reg      <= hcnt_next;
            fmt_found_reg <= fmt_found_next;
            fmt_off_reg   <= fmt_off_next;
            data_seen_reg <= data_seen_next;
            data_off_reg  <= data_off_next;
            data_len_reg  <= data_len_next;
        end
    end

    assign res_valid       = fin;
    assign res.status      = fin_status;
    assign res.fmt_offset  = fmt_off_next;
    assign res.data_offset = data_off_next;
    assign res.data_size   = data_len_next;

endmodule

// ----- hw/rtl/riff_wave_chunk_locator.sv -----
`timescale 1ns / 1ps
// ============================================================================
// riff_wave_chunk_locator
// Locates the fmt and data chunks of a RIFF/WAVE byte stream.
// ============================================================================
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+--------------------------------------
//  byte     | byte_valid / byte_ready     | byte_word   (data_byte, start_req)
//  result   | result_valid / result_ready | result_word (status, offsets, size)
//  config   | psel/penable/pwrite, APB    | need_format at paddr 0
//
//  One byte per clock while no result waits. A byte goes input register ->
//  parse logic -> result register. A byte in the input register is parsed
//  only when the result register is empty or being drained. While a result
//  waits there, parsing stops and byte_ready drops as soon as the input
//  register holds a byte. Reset clears all parse state and sets need_format.
//
//  The per-byte path is bounded by the chunk-length step: round-up of the
//  32-bit length, the 33-bit next-chunk add and the end compare. Body offset
//  and remaining room are precomputed on the first header bytes.
// ============================================================================
module riff_wave_chunk_locator
    import rwcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               byte_valid,
    output logic               byte_ready,
    input  byte_word_t         byte_word,

    output logic               result_valid,
    input  logic               result_ready,
    output result_word_t       result_word,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // input register
    logic         in_valid_reg, in_valid_next;
    byte_word_t   in_word_reg, in_word_next;

    // result register
    logic         out_valid_reg, out_valid_next;
    result_word_t out_word_reg, out_word_next;

    logic         need_format;
    logic         step;
    logic         res_valid;
    result_word_t res;

    rwcl_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .need_format (need_format)
    );

    // Parse a held byte whenever the result slot can take a possible result
    assign step       = in_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || step;

    rwcl_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_word_reg),
        .need_format (need_format),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_word_next   = in_word_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (byte_ready)
        begin
            in_valid_next = byte_valid;
            in_word_next  = byte_word;
        end

        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step && res_valid)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule
